// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- src/bmg_pkg.sv -----
// ----------------------------------------------------------------------------
// Box-Muller generator package
// Shared widths, constants and the request type passed from front to back.
// ----------------------------------------------------------------------------
package bmg_pkg;
  localparam int UniformBits = 32;
  localparam int AngleBits   = 16;
  localparam int OutFracBits = 12;
  localparam int QDepth      = 2;
  localparam int QPtrW       = 1;

  // Width of 1 - u as an integer, and the rounding shift of the final product.
  localparam int UniformW    = UniformBits + 1;
  localparam int RoundSh     = 43 - OutFracBits;

  localparam logic [31:0] TwoLn2Q30 = 32'd1488522236;

  // Quarter-wave sine coefficients, .30, index 0 is the linear term.
  localparam logic [31:0] SinCoef [6] = '{
    32'd1686629713, 32'd693598668, 32'd85569306,
    32'd5026995, 32'd172272, 32'd3864
  };

  // One classified request: fresh pair draw or sine half from kept pair.
  typedef struct packed {
    logic                   fresh;
    logic [UniformBits-1:0] u;
    logic [AngleBits-1:0]   v;
  } bmg_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_LOG, ST_LOGMUL, ST_ROOT,
    ST_SINPREP, ST_HORNER, ST_SINFIN, ST_PROD
  } bmg_state_e;
endpackage

// ----- src/bmg_front.sv -----
// ----------------------------------------------------------------------------
// Box-Muller front end
// Accepts requests, marks each as fresh or second half, queues them.
// ----------------------------------------------------------------------------
module bmg_front import bmg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [UniformBits-1:0] uniform_radius_i,
  input  logic [AngleBits-1:0]   uniform_angle_i,
  output logic                   req_valid_o,
  output bmg_req_t               req_o,
  input  logic                   req_take_i
);
  bmg_req_t      mem_q [QDepth];
  logic [QPtrW:0] wr_q, rd_q;
  logic          fresh_q;
  logic          wr_en, rd_en;

  assign full        = (wr_q[QPtrW] != rd_q[QPtrW]) && (wr_q[QPtrW-1:0] == rd_q[QPtrW-1:0]);
  assign req_valid_o = (wr_q != rd_q);
  assign wr_en       = push && !full;
  assign rd_en       = req_take_i && req_valid_o;
  assign req_o       = mem_q[rd_q[QPtrW-1:0]];

  // Pointers and the fresh/second-half toggle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      fresh_q <= 1'b1;
    end else begin
      if (wr_en) begin
        wr_q    <= wr_q + 1'b1;
        fresh_q <= !fresh_q;
      end
      if (rd_en) rd_q <= rd_q + 1'b1;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q[QPtrW-1:0]] <= '{fresh: fresh_q, u: uniform_radius_i,
                                           v: uniform_angle_i};
  end
endmodule

// ----- src/bmg_back.sv -----
// ----------------------------------------------------------------------------
// Box-Muller back end
// Sequencer computing radius, angle and the scaled sine or cosine.
// ----------------------------------------------------------------------------
module bmg_back import bmg_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  bmg_req_t       req_i,
  output logic           req_take_o,
  output logic           empty,
  input  logic           pop,
  output logic [15:0]    gauss_sample_o,
  output logic           second_half_o
);
  bmg_state_e state_q, state_d;
  logic                fresh_q;
  logic [UniformW-1:0] t_q;
  logic [5:0]          shift_q;
  logic [4:0]          cnt_q;
  logic [31:0]         x_q;
  logic [23:0]         frac_q;
  logic [33:0]         rad_q;
  logic [19:0]         rem_q;
  logic [16:0]         root_q;
  logic [15:0]         radius_q, angle_q;
  logic [31:0]         s2n_q, s2f_q, accn_q, accf_q, sn_q, sf_q;
  logic [15:0]         out_q;
  logic                out_v_q, out_h_q;

  logic [31:0] mna, mnb, mfa, mfb;
  logic [63:0] pn, pf;
  logic [29:0] n_log;
  logic [30:0] z, zf;
  logic [19:0] rem_sh, trial;
  logic        root_ge;
  logic [16:0] root_nx;
  logic [1:0]  quad;
  logic        neg;
  logic [31:0] ssel;
  logic [63:0] mag;
  logic [2:0]  k;
  logic        load;
  logic [15:0] sample_d;

  assign empty          = !out_v_q;
  assign gauss_sample_o = out_q;
  assign second_half_o  = out_h_q;
  assign req_take_o     = (state_q == ST_IDLE) && req_valid_i;
  assign load           = (state_q == ST_PROD) && (!out_v_q || pop);

  // Log result in .24, quarter angles and one root step.
  assign n_log   = {shift_q, 24'd0} - {6'd0, frac_q};
  assign z       = {1'b0, angle_q[13:0], 16'd0};
  assign zf      = 31'h4000_0000 - z;
  assign rem_sh  = {rem_q[17:0], rad_q[33:32]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign root_ge = (rem_sh >= trial);
  assign root_nx = {root_q[15:0], root_ge};
  assign quad    = angle_q[15:14];
  assign k       = 3'd4 - cnt_q[2:0];

  // Two shared multipliers, near and far side.
  assign pn  = {32'd0, mna} * {32'd0, mnb};
  assign pf  = {32'd0, mfa} * {32'd0, mfb};
  assign mag = (pn + (64'd1 << (RoundSh - 1))) >> RoundSh;

  // Multiplier operands for each step.
  always_comb begin
    mna = '0;
    mnb = '0;
    mfa = '0;
    mfb = '0;
    case (state_q)
      ST_LOG: begin
        mna = x_q;
        mnb = x_q;
      end
      ST_LOGMUL: begin
        mna = {2'b00, n_log};
        mnb = TwoLn2Q30;
      end
      ST_SINPREP: begin
        mna = {1'b0, z};
        mnb = {1'b0, z};
        mfa = {1'b0, zf};
        mfb = {1'b0, zf};
      end
      ST_HORNER: begin
        mna = accn_q;
        mnb = s2n_q;
        mfa = accf_q;
        mfb = s2f_q;
      end
      ST_SINFIN: begin
        mna = accn_q;
        mnb = {1'b0, z};
        mfa = accf_q;
        mfb = {1'b0, zf};
      end
      ST_PROD: begin
        mna = {16'd0, radius_q};
        mnb = ssel;
      end
      default: ;
    endcase
  end

  // Quadrant selection of the sine side and the sign.
  always_comb begin
    if (fresh_q) begin
      ssel = (quad inside {2'd0, 2'd2}) ? sf_q : sn_q;
      neg  = (quad inside {2'd1, 2'd2});
    end else begin
      ssel = (quad inside {2'd0, 2'd2}) ? sn_q : sf_q;
      neg  = quad[1];
    end
  end

  // Saturate the rounded magnitude to 16 bits with its sign.
  always_comb begin
    if (neg) sample_d = (mag > 64'd32768) ? 16'h8000 : 16'd0 - mag[15:0];
    else     sample_d = (mag > 64'd32767) ? 16'h7FFF : mag[15:0];
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (req_valid_i) state_d = req_i.fresh ? ST_NORM : ST_SINPREP;
      ST_NORM:    if (t_q[UniformW-1]) state_d = ST_LOG;
      ST_LOG:     if (cnt_q == 5'd23) state_d = ST_LOGMUL;
      ST_LOGMUL:  state_d = ST_ROOT;
      ST_ROOT:    if (cnt_q == 5'd16) state_d = ST_SINPREP;
      ST_SINPREP: state_d = ST_HORNER;
      ST_HORNER:  if (cnt_q == 5'd4) state_d = ST_SINFIN;
      ST_SINFIN:  state_d = ST_PROD;
      ST_PROD:    if (load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q  <= 1'b1;
      t_q      <= '0;
      shift_q  <= '0;
      cnt_q    <= '0;
      x_q      <= '0;
      frac_q   <= '0;
      rad_q    <= '0;
      rem_q    <= '0;
      root_q   <= '0;
      radius_q <= '0;
      angle_q  <= '0;
      s2n_q    <= '0;
      s2f_q    <= '0;
      accn_q   <= '0;
      accf_q   <= '0;
      sn_q     <= '0;
      sf_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: if (req_valid_i) begin
          fresh_q <= req_i.fresh;
          t_q     <= {1'b1, {UniformBits{1'b0}}} - {1'b0, req_i.u};
          shift_q <= '0;
          if (req_i.fresh) angle_q <= 16'({req_i.v, 16'd0} >> AngleBits);
        end
        ST_NORM: begin
          // Shift 1 - u up until its top bit is set, counting the shifts.
          if (t_q[UniformW-1]) begin
            x_q    <= 32'({t_q, 31'd0} >> UniformW);
            frac_q <= '0;
            cnt_q  <= '0;
          end else begin
            t_q     <= {t_q[UniformW-2:0], 1'b0};
            shift_q <= shift_q + 6'd1;
          end
        end
        ST_LOG: begin
          // One fraction bit of log2 per squaring.
          cnt_q <= cnt_q + 5'd1;
          if (pn[61]) begin
            x_q    <= pn[62:31];
            frac_q <= {frac_q[22:0], 1'b1};
          end else begin
            x_q    <= pn[61:30];
            frac_q <= {frac_q[22:0], 1'b0};
          end
        end
        ST_LOGMUL: begin
          rad_q  <= {pn[61:30], 2'b00};
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= '0;
        end
        ST_ROOT: begin
          // One root bit per cycle, two radicand bits shifted in.
          cnt_q  <= cnt_q + 5'd1;
          rem_q  <= root_ge ? rem_sh - trial : rem_sh;
          root_q <= root_nx;
          rad_q  <= {rad_q[31:0], 2'b00};
          if (cnt_q == 5'd16) radius_q <= root_nx[16] ? 16'hFFFF : root_nx[15:0];
        end
        ST_SINPREP: begin
          s2n_q  <= pn[61:30];
          s2f_q  <= pf[61:30];
          accn_q <= SinCoef[5];
          accf_q <= SinCoef[5];
          cnt_q  <= '0;
        end
        ST_HORNER: begin
          // Horner step for both quarter angles, one coefficient a cycle.
          cnt_q  <= cnt_q + 5'd1;
          accn_q <= SinCoef[k] - pn[61:30];
          accf_q <= SinCoef[k] - pf[61:30];
        end
        ST_SINFIN: begin
          sn_q <= pn[61:30];
          sf_q <= pf[61:30];
        end
        default: ;
      endcase
    end
  end

  // Result register, loaded only once the previous result has gone.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      out_h_q <= 1'b0;
      out_q   <= '0;
    end else if (load) begin
      out_v_q <= 1'b1;
      out_h_q <= !fresh_q;
      out_q   <= sample_d;
    end else if (pop && out_v_q) begin
      out_v_q <= 1'b0;
    end
  end
endmodule

// ----- src/box_muller_gaussian_generator_core.sv -----
// Sequence: a fresh draw runs a leading-one search of up to 33 steps, 24 log squarings,
// 17 root steps and 5 Horner steps; a second half goes straight to the sine steps.
// Flow: one request in the back end at a time, and a waiting result holds the back end.
// Reset: asynchronous, active low; queue empties, next request draws a fresh pair.
// ----------------------------------------------------------------------------
// Box-Muller Gaussian generator top level
// Front queue and sequential back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module box_muller_gaussian_generator_core import bmg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [UniformBits-1:0] uniform_radius_i,
  input  logic [AngleBits-1:0]   uniform_angle_i,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [15:0]     gauss_sample_o,
  output logic                   second_half_o
);
  logic     req_valid, req_take;
  bmg_req_t req;
  logic [15:0] sample;

  bmg_front u_front (
    .clk_i, .rst_ni, .push, .full, .uniform_radius_i, .uniform_angle_i,
    .req_valid_o(req_valid), .req_o(req), .req_take_i(req_take)
  );

  bmg_back u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .req_take_o(req_take),
    .empty, .pop, .gauss_sample_o(sample), .second_half_o
  );

  assign gauss_sample_o = signed'(sample);

  `ASSERT_IMPLIES(a_take_valid, clk_i, rst_ni, req_take, req_valid)
  `ASSERT_NEXT(a_sample_held, clk_i, rst_ni, !empty && !pop, !empty && $stable({sample, second_half_o}))
endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box-Muller Gaussian generator testbench
// Drives uniform pairs into the generator under several idling patterns,
// predicts each sample with a fixed-point Box-Muller model and compares
// every popped sample against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import bmg_pkg::*;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               sine_half;
  } gauss_out_t;

  // Predicts samples from accepted requests and checks popped ones.
  class gauss_scoreboard;
    bit           want_fresh;
    logic [15:0]  radius;
    logic [15:0]  angle;
    gauss_out_t   pending[$];
    int           errors;
    int           checked;

    function new();
      want_fresh = 1'b1;
      radius     = '0;
      angle      = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b   = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // sin(pi/2 * z) with z in 1.30, result in .30.
    function logic [63:0] qsine(logic [63:0] z);
      logic [63:0] sq;
      logic [63:0] acc;
      sq  = (z * z) >> 30;
      acc = 64'(SinCoef[5]);
      for (int k = 4; k >= 0; k--) acc = 64'(SinCoef[k]) - ((acc * sq) >> 30);
      return (acc * z) >> 30;
    endfunction

    // Radius sqrt(-2 ln(1-u)) in 3.13 via a log2 by repeated squaring.
    function logic [15:0] draw_radius(logic [UniformBits-1:0] u);
      logic [63:0] t;
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] n;
      logic [63:0] w;
      logic [63:0] r;
      int          p;
      t    = (64'd1 << UniformBits) - 64'(u);
      p    = 0;
      frac = '0;
      while (p < 63 && (t >> (p + 1)) != 0) p++;
      x = (p >= 30) ? (t >> (p - 30)) : (t << (30 - p));
      for (int i = 1; i <= 24; i++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x    = x >> 1;
          frac = frac | (64'd1 << (24 - i));
        end
      end
      n = (64'(UniformBits - p) << 24) - frac;
      w = (n * 64'(TwoLn2Q30)) >> 30;
      r = isqrt(w << 2);
      return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function void note_request(logic [UniformBits-1:0] u, logic [AngleBits-1:0] v);
      bit          fresh;
      logic [1:0]  quad;
      logic [63:0] z;
      logic [63:0] s_near;
      logic [63:0] s_far;
      logic [63:0] s;
      logic [63:0] mag;
      bit          neg;
      gauss_out_t  res;
      int          sh;
      fresh = want_fresh;
      if (fresh) begin
        radius     = draw_radius(u);
        angle      = 16'({v, 16'd0} >> AngleBits);
        want_fresh = 1'b0;
      end else begin
        want_fresh = 1'b1;
      end
      quad   = angle[15:14];
      z      = 64'(angle[13:0]) << 16;
      s_near = qsine(z);
      s_far  = qsine((64'd1 << 30) - z);
      if (fresh) begin
        s   = (quad == 0 || quad == 2) ? s_far : s_near;
        neg = (quad == 1 || quad == 2);
      end else begin
        s   = (quad == 0 || quad == 2) ? s_near : s_far;
        neg = (quad >= 2);
      end
      sh  = 43 - OutFracBits;
      mag = (64'(radius) * s + (64'd1 << (sh - 1))) >> sh;
      if (neg) res.sample = (mag > 64'd32768) ? 16'h8000 : 16'(-mag);
      else     res.sample = (mag > 64'd32767) ? 16'h7FFF : 16'(mag);
      res.sine_half = !fresh;
      pending.push_back(res);
    endfunction

    function void check_sample(logic signed [15:0] sample, logic sine_half);
      gauss_out_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected sample %0d with no request outstanding", sample);
        errors++;
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (sample !== exp_res.sample) begin
        $error("gauss_sample: expected %0d, got %0d", exp_res.sample, sample);
        errors++;
      end
      if (sine_half !== exp_res.sine_half) begin
        $error("second_half: expected %0b, got %0b", exp_res.sine_half, sine_half);
        errors++;
      end
    endfunction
  endclass

  localparam int StallLimit = 20000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   push;
  logic                   full;
  logic [UniformBits-1:0] uniform_radius_i;
  logic [AngleBits-1:0]   uniform_angle_i;
  logic                   empty;
  logic                   pop;
  logic signed [15:0]     gauss_sample_o;
  logic                   second_half_o;

  gauss_scoreboard sb;
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  idle_cycles;
  int  sent;

  box_muller_gaussian_generator_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .uniform_radius_i (uniform_radius_i),
    .uniform_angle_i  (uniform_angle_i),
    .empty            (empty),
    .pop              (pop),
    .gauss_sample_o   (gauss_sample_o),
    .second_half_o    (second_half_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Record accepted requests and check popped samples at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.note_request(uniform_radius_i, uniform_angle_i);
        sent++;
      end
      if (pop && !empty) sb.check_sample(gauss_sample_o, second_half_o);
      idle_cycles = ((push && !full) || (pop && !empty)) ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stalls, with an optional long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni || hold_off) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one request; returns at the falling edge after it has been accepted.
  task automatic send_request(logic [UniformBits-1:0] u, logic [AngleBits-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push             <= 1'b1;
    uniform_radius_i <= u;
    uniform_angle_i  <= v;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [UniformBits-1:0] u;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       u = '0;
        1:       u = '1 - UniformBits'($urandom_range(255));
        2:       u = UniformBits'($urandom_range(255));
        3:       u = UniformBits'(1) << $urandom_range(UniformBits - 1);
        default: u = $urandom;
      endcase
      send_request(u, AngleBits'($urandom));
    end
    push <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    sb               = new();
    rst_ni           = 1'b0;
    push             = 1'b0;
    pop              = 1'b0;
    hold_off         = 1'b0;
    uniform_radius_i = '0;
    uniform_angle_i  = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    idle_cycles      = 0;
    sent             = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero and extreme uniforms, each quadrant boundary of the angle.
    send_request('0, '0);
    send_request('1, '1);
    send_request('1, '0);
    send_request('0, '0);
    send_request(32'h0000_0001, 16'h4000);
    send_request('0, '0);
    send_request(32'h8000_0000, 16'h8000);
    send_request('1, '1);
    send_request(32'hFFFF_FF00, 16'hC000);
    send_request('0, '1);
    send_request(32'hFFFF_FFFF, 16'h3FFF);
    send_request('0, '0);
    send_request(32'hFFFF_FFFE, 16'h7FFF);
    send_request('0, '0);
    send_request(32'h5555_5555, 16'hAAAA);
    send_request(32'hAAAA_AAAA, 16'h5555);
    send_request(32'hFFFF_FFFF, 16'hBFFF);
    send_request('1, '0);
    send_request(32'hFFFF_FFFF, 16'hFFFF);
    send_request('0, '0);
    push <= 1'b0;
    drain();

    // Long receiver hold-off so the queue fills and stalls the sender.
    hold_off = 1'b1;
    fork
      send_random(12);
      begin
        repeat (600) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();

    // Random phases under each idling pattern.
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(420); drain();
    send_idle_pct = 62; recv_stall_pct = 0;  send_random(420); drain();
    send_idle_pct = 0;  recv_stall_pct = 62; send_random(420); drain();
    send_idle_pct = 10; recv_stall_pct = 10; send_random(420); drain();

    $display("Covered %0d requests and %0d checked samples across four idling phases,",
             sent, sb.checked);
    $display("including a long receiver hold-off with the input stalled.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
